@@ hw/rtl/calibrated_overvoltage_monitor_core_assert.svh @@
// assertion macros used by the checker file
`ifndef CALIBRATED_OVERVOLTAGE_MONITOR_CORE_ASSERT_SVH
`define CALIBRATED_OVERVOLTAGE_MONITOR_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define COVM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define COVM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/covm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// covm_pkg
// shared types and constants of the overvoltage monitor
// ----------------------------------------------------------------------------
package covm_pkg;

  localparam int unsigned TablePointsDef = 8;
  localparam int unsigned CodeBitsDef    = 12;
  localparam int unsigned MvW            = 22;
  localparam int unsigned LimitW         = 21;
  localparam logic [LimitW-1:0] LimitRst = 21'd500000;

  typedef enum logic [2:0] {
    MODE_SAMPLE  = 3'd0,
    MODE_CONNECT = 3'd1,
    MODE_DISCON  = 3'd2,
    MODE_FRESET  = 3'd3,
    MODE_CLEAR   = 3'd4,
    MODE_DEADZ   = 3'd5,
    MODE_ADD     = 3'd6,
    MODE_FINISH  = 3'd7
  } covm_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIRST,
    ST_LAST,
    ST_SRCH,
    ST_LO,
    ST_HI,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_FIN,
    ST_TRIP,
    ST_SORT,
    ST_DONE
  } covm_state_e;

  // control shared by all table cells
  typedef struct packed {
    logic clear;
    logic sort;
    logic phase;
  } covm_cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/covm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// covm_cell
// one calibration point, with compare-exchange against its neighbours
// ----------------------------------------------------------------------------
module covm_cell #(
  parameter int unsigned Idx   = 0,
  parameter int unsigned CodeW = 12,
  parameter int unsigned CntW  = 4
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  covm_pkg::covm_cell_ctrl_t    ctrl_i,
  input  wire  [CntW-1:0]              count_i,
  input  wire                          wr_i,
  input  wire  [CodeW-1:0]             wr_code_i,
  input  wire  [covm_pkg::MvW-1:0]     wr_mv_i,
  input  wire  [CodeW-1:0]             left_code_i,
  input  wire  [covm_pkg::MvW-1:0]     left_mv_i,
  input  wire  [CodeW-1:0]             right_code_i,
  input  wire  [covm_pkg::MvW-1:0]     right_mv_i,
  output logic [CodeW-1:0]             code_o,
  output logic [covm_pkg::MvW-1:0]     mv_o
);
  import covm_pkg::*;

  localparam logic       MyPar  = 1'(Idx % 2);
  localparam logic [CntW:0] NextIdx = (CntW+1)'(Idx + 1);
  localparam logic [CntW:0] SelfIdx = (CntW+1)'(Idx);

  logic [CodeW-1:0] code_q, code_d;
  logic [MvW-1:0]   mv_q, mv_d;
  logic             left_role, right_role;

  // pairs (2k+p, 2k+p+1) exchange in round of parity p, only inside the table
  assign left_role  = ctrl_i.sort && (MyPar == ctrl_i.phase) &&
                      (NextIdx < {1'b0, count_i});
  assign right_role = ctrl_i.sort && (Idx > 0) && (MyPar != ctrl_i.phase) &&
                      (SelfIdx < {1'b0, count_i});

  always_comb begin
    code_d = code_q;
    mv_d   = mv_q;
    if (ctrl_i.clear) begin
      code_d = '0;
      mv_d   = '0;
    end else if (wr_i) begin
      code_d = wr_code_i;
      mv_d   = wr_mv_i;
    end else if (left_role && (code_q > right_code_i)) begin
      code_d = right_code_i;
      mv_d   = right_mv_i;
    end else if (right_role && (left_code_i > code_q)) begin
      code_d = left_code_i;
      mv_d   = left_mv_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      mv_q   <= '0;
    end else begin
      code_q <= code_d;
      mv_q   <= mv_d;
    end
  end

  assign code_o = code_q;
  assign mv_o   = mv_q;

endmodule

`default_nettype wire

@@ hw/rtl/covm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// covm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module covm_div #(
  parameter int unsigned DivdW = 36,
  parameter int unsigned DivsW = 12
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire  [DivdW-1:0] dividend_i,
  input  wire  [DivsW-1:0] divisor_i,
  output logic             done_o,
  output logic [DivdW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(DivdW + 1);

  logic [DivdW-1:0] quo_q, quo_d;
  logic [DivsW:0]   rem_q, rem_d;
  logic [DivsW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DivsW+1:0] trial;

  assign trial = {rem_q, quo_q[DivdW-1]} - {2'b00, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DivdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[DivsW+1]) begin
        rem_d = {rem_q[DivsW-1:0], quo_q[DivdW-1]};
        quo_d = {quo_q[DivdW-2:0], 1'b0};
      end else begin
        rem_d = trial[DivsW:0];
        quo_d = {quo_q[DivdW-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/calibrated_overvoltage_monitor_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calibrated_overvoltage_monitor_core
// overvoltage monitor with a piecewise linear calibration table
// ----------------------------------------------------------------------------
// usage
//   commands enter on the s_axis channel: tuser carries the mode, tdata the
//   adc code and the reference voltage. every item gives exactly one result
//   item on m_axis: last voltage, fault latch, relay, accepted flag, count.
//   the trip limit is written through the apb port (register 0, address 0).
// processing
//   one item at a time: s_axis is ready only while idle. relay, fault and
//   table commands pass through the execute and done states; the result
//   is registered from the done state. finish runs odd-even exchange rounds
//   across the cell row. a sample above the dead zone, with two points or
//   more, runs clamp checks against the first and last points, a binary
//   search, one multiply and a serial divide of CODE_BITS + 23 steps.
// reset
//   table, count, dead zone, fault, relay and voltage clear, limit goes to
//   500000 mV; no clearing pass is needed.
// stalls
//   a result waits in the output register until taken; the next item is taken
//   meanwhile and its result waits in the engine until the register frees.
// ----------------------------------------------------------------------------
module calibrated_overvoltage_monitor_core #(
  parameter int unsigned TABLE_POINTS = covm_pkg::TablePointsDef,
  parameter int unsigned CODE_BITS    = covm_pkg::CodeBitsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // apb configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,  // [11:0] sample_code, [33:12] known_mv, rest zero
  input  wire  [2:0]  s_axis_tuser,  // [2:0] mode
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata   // [21:0] voltage_mv, [22] over_voltage,
                                     // [23] relay_closed, [24] accepted,
                                     // [28:25] point_count, rest zero
);
  import covm_pkg::*;

  localparam int unsigned CW   = CODE_BITS;
  localparam int unsigned NW   = $clog2(TABLE_POINTS + 1);
  localparam int unsigned IW   = $clog2(TABLE_POINTS);
  localparam int unsigned PW   = CW + 24;   // signed product width
  localparam int unsigned DW   = PW - 1;    // product magnitude
  localparam int unsigned SW   = PW + 1;    // sum before saturation

  // ---- configuration register ----
  logic [LimitW-1:0] limit_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {11'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
    end else if (cfg_wr) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  // ---- control state ----
  covm_state_e       state_q, state_d;
  covm_mode_e        mode_q, mode_d;
  logic [CW-1:0]     code_q, code_d;
  logic [MvW-1:0]    kmv_q, kmv_d;
  logic [NW-1:0]     count_q, count_d;
  logic [CW-1:0]     dz_q, dz_d;
  logic              fault_q, fault_d, relay_q, relay_d, ok_q, ok_d;
  logic [MvW-1:0]    lv_q, lv_d;
  logic [IW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]     clo_q, clo_d;
  logic [MvW-1:0]    mlo_q, mlo_d;
  logic [CW:0]       dx_q, dx_d, dc_q, dc_d;
  logic [MvW:0]      dy_q, dy_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic              neg_q, neg_d;
  logic [NW-1:0]     rnd_q, rnd_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_data_q, out_data_d;

  // ---- cell row ----
  covm_cell_ctrl_t   ctrl;
  logic              append_en;
  logic [CW-1:0]     cell_code [TABLE_POINTS];
  logic [MvW-1:0]    cell_mv   [TABLE_POINTS];
  logic [CW-1:0]     in_code;
  logic [15:0]       in_code_wide;

  assign in_code_wide = {4'd0, s_axis_tdata[11:0]};
  assign in_code      = in_code_wide[CW-1:0];

  for (genvar i = 0; i < TABLE_POINTS; i++) begin : g_cell
    logic [CW-1:0]  lc, rc;
    logic [MvW-1:0] lm, rm;
    if (i > 0) begin : g_l
      assign lc = cell_code[i-1];
      assign lm = cell_mv[i-1];
    end else begin : g_l0
      assign lc = '0;
      assign lm = '0;
    end
    if (i < TABLE_POINTS - 1) begin : g_r
      assign rc = cell_code[i+1];
      assign rm = cell_mv[i+1];
    end else begin : g_rn
      assign rc = '0;
      assign rm = '0;
    end
    covm_cell #(.Idx(i), .CodeW(CW), .CntW(NW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .wr_i        (append_en && (count_q == NW'(i))),
      .wr_code_i   (code_q),
      .wr_mv_i     (kmv_q),
      .left_code_i (lc),
      .left_mv_i   (lm),
      .right_code_i(rc),
      .right_mv_i  (rm),
      .code_o      (cell_code[i]),
      .mv_o        (cell_mv[i])
    );
  end

  // one table read per cycle, address set by the state
  logic [IW-1:0]  rd_idx;
  logic [IW:0]    mid_sum;
  logic [IW-1:0]  mid;
  logic [NW-1:0]  last_n;
  logic [CW-1:0]  rd_code;
  logic [MvW-1:0] rd_mv;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IW:1];
  assign last_n  = count_q - 1'b1;

  always_comb begin
    case (state_q)
      ST_FIRST: rd_idx = '0;
      ST_LAST:  rd_idx = last_n[IW-1:0];
      ST_SRCH:  rd_idx = mid;
      ST_LO:    rd_idx = lo_q;
      ST_HI:    rd_idx = hi_q;
      default:  rd_idx = '0;
    endcase
  end

  assign rd_code = cell_code[rd_idx];
  assign rd_mv   = cell_mv[rd_idx];

  // ---- divider ----
  logic            div_start, div_done;
  logic [DW-1:0]   div_quot, prod_abs;
  logic [PW-1:0]   prod_neg;
  logic [CW-1:0]   dx_abs;
  logic [CW:0]     dx_neg;

  assign prod_neg = -prod_q;
  assign prod_abs = prod_q[PW-1] ? prod_neg[DW-1:0] : prod_q[DW-1:0];
  assign dx_neg   = -dx_q;
  assign dx_abs   = dx_q[CW] ? dx_neg[CW-1:0] : dx_q[CW-1:0];
  assign div_start = (state_q == ST_DIVGO);

  covm_div #(.DivdW(DW), .DivsW(CW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_abs),
    .divisor_i (dx_abs),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // signed quotient plus lower voltage, then saturate to 22 bits
  logic [PW-1:0] q_pos, q_sgn;
  logic [SW-1:0] sum;
  logic [MvW-1:0] sat;
  logic [SW-MvW:0] top_bits;

  assign q_pos    = {1'b0, div_quot};
  assign q_sgn    = neg_q ? -q_pos : q_pos;
  assign sum      = {{(SW-MvW){mlo_q[MvW-1]}}, mlo_q} + {q_sgn[PW-1], q_sgn};
  assign top_bits = sum[SW-1:MvW-1];
  assign sat      = ((top_bits == '0) || (top_bits == '1)) ? sum[MvW-1:0] :
                    (sum[SW-1] ? {1'b1, {(MvW-1){1'b0}}} : {1'b0, {(MvW-1){1'b1}}});

  logic [NW:0] hl_diff;
  assign hl_diff = {1'b0, {(NW-IW){1'b0}}, hi_q} - {1'b0, {(NW-IW){1'b0}}, lo_q};

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    code_d      = code_q;
    kmv_d       = kmv_q;
    count_d     = count_q;
    dz_d        = dz_q;
    fault_d     = fault_q;
    relay_d     = relay_q;
    ok_d        = ok_q;
    lv_d        = lv_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    clo_d       = clo_q;
    mlo_d       = mlo_q;
    dx_d        = dx_q;
    dc_d        = dc_q;
    dy_d        = dy_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ctrl        = '0;
    append_en   = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = covm_mode_e'(s_axis_tuser);
          code_d  = in_code;
          kmv_d   = s_axis_tdata[33:12];
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ok_d    = 1'b1;
        state_d = ST_DONE;
        case (mode_q)
          MODE_SAMPLE: begin
            if ((code_q <= dz_q) || (count_q < NW'(2))) begin
              lv_d    = '0;
              state_d = ST_TRIP;
            end else begin
              state_d = ST_FIRST;
            end
          end
          MODE_CONNECT: if (!fault_q) relay_d = 1'b1;
          MODE_DISCON:  relay_d = 1'b0;
          MODE_FRESET: begin
            relay_d = 1'b0;
            fault_d = 1'b0;
          end
          MODE_CLEAR: begin
            ctrl.clear = 1'b1;
            count_d    = '0;
            dz_d       = '0;
          end
          MODE_DEADZ, MODE_ADD: begin
            if (mode_q == MODE_DEADZ) dz_d = code_q;
            if (count_q < NW'(TABLE_POINTS)) begin
              append_en = 1'b1;
              count_d   = count_q + 1'b1;
            end else if (mode_q == MODE_ADD) begin
              ok_d = 1'b0;
            end
          end
          MODE_FINISH: begin
            if (count_q < NW'(2)) begin
              ok_d = 1'b0;
            end else begin
              rnd_d   = '0;
              state_d = ST_SORT;
            end
          end
          default: ;
        endcase
      end
      ST_FIRST: begin
        if (code_q <= rd_code) begin
          lv_d    = rd_mv;
          state_d = ST_TRIP;
        end else begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (code_q >= rd_code) begin
          lv_d    = rd_mv;
          state_d = ST_TRIP;
        end else begin
          lo_d    = '0;
          hi_d    = last_n[IW-1:0];
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (hl_diff > (NW+1)'(1)) begin
          if (code_q >= rd_code) lo_d = mid;
          else hi_d = mid;
        end else begin
          state_d = ST_LO;
        end
      end
      ST_LO: begin
        clo_d   = rd_code;
        mlo_d   = rd_mv;
        state_d = ST_HI;
      end
      ST_HI: begin
        dx_d = {1'b0, rd_code} - {1'b0, clo_q};
        dc_d = {1'b0, code_q} - {1'b0, clo_q};
        dy_d = {rd_mv[MvW-1], rd_mv} - {mlo_q[MvW-1], mlo_q};
        if (rd_code == clo_q) begin
          lv_d    = mlo_q;
          state_d = ST_TRIP;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = PW'($signed(dc_q) * $signed(dy_q));
        state_d = ST_DIVGO;
      end
      ST_DIVGO: begin
        neg_d   = prod_q[PW-1] ^ dx_q[CW];
        state_d = ST_DIV;
      end
      ST_DIV: if (div_done) state_d = ST_FIN;
      ST_FIN: begin
        lv_d    = sat;
        state_d = ST_TRIP;
      end
      ST_TRIP: begin
        // strictly above the limit trips, only when not already latched
        if (!fault_q && !lv_q[MvW-1] && (lv_q[LimitW-1:0] > limit_q)) begin
          relay_d = 1'b0;
          fault_d = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_SORT: begin
        ctrl.sort  = 1'b1;
        ctrl.phase = rnd_q[0];
        rnd_d      = rnd_q + 1'b1;
        if (rnd_q == NW'(TABLE_POINTS - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'd0, 4'(count_q), ok_q, relay_q, fault_q, lv_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dz_q        <= '0;
      fault_q     <= 1'b0;
      relay_q     <= 1'b0;
      ok_q        <= 1'b1;
      lv_q        <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dz_q        <= dz_d;
      fault_q     <= fault_d;
      relay_q     <= relay_d;
      ok_q        <= ok_d;
      lv_q        <= lv_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    code_q     <= code_d;
    kmv_q      <= kmv_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    clo_q      <= clo_d;
    mlo_q      <= mlo_d;
    dx_q       <= dx_d;
    dc_q       <= dc_d;
    dy_q       <= dy_d;
    prod_q     <= prod_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/covm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// covm_checker
// port-level checks of the overvoltage monitor
// ----------------------------------------------------------------------------
`include "calibrated_overvoltage_monitor_core_assert.svh"

module covm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata
);

  // a result waiting for the receiver stays put
  `COVM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // one item in work at a time
  `COVM_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a latched fault never shows with the relay closed
  `COVM_ASSERT_SAME(a_fault_open, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[22], !m_axis_tdata[23])

endmodule

bind calibrated_overvoltage_monitor_core covm_checker u_covm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the calibrated overvoltage monitor: commands and samples are
// driven on the input stream, each result item is checked against an in-bench
// model of the calibration table, fault latch and relay
// ----------------------------------------------------------------------------
module tb_top;
  import covm_pkg::*;

  localparam int NPTS      = 8;
  localparam int WDOG_MAX  = 20000;
  localparam longint MVMAX = 2097151;
  localparam longint MVMIN = -2097152;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [11:0] sample_code, [33:12] known_mv
  logic [2:0]  s_axis_tuser = '0;   // [2:0] mode
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [31:0] m_axis_tdata;        // [21:0] voltage_mv, [22] over_voltage,
                                    // [23] relay_closed, [24] accepted,
                                    // [28:25] point_count

  always #2 clk_i = ~clk_i;

  calibrated_overvoltage_monitor_core u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // model state of the monitor
  logic [11:0]        cal_code[NPTS];
  logic signed [21:0] cal_mv[NPTS];
  int                 cal_count;
  logic [11:0]        dz_code;
  logic               fault_q, relay_q;
  logic signed [21:0] volt_q;
  logic [20:0]        limit_q;

  logic [31:0] result_q[$];
  int          errors = 0;
  int          idle_pct = 29;     // percentage of idle cycles on each side
  bit          hold_sink = 1'b0;  // long receiver hold-off when set

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [21:0] convert_code(input logic [11:0] code);
    int lo, hi, mid;
    longint dx, num, v;
    if (code <= dz_code || cal_count < 2) return '0;
    if (code <= cal_code[0]) return cal_mv[0];
    if (code >= cal_code[cal_count-1]) return cal_mv[cal_count-1];
    lo = 0;
    hi = cal_count - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (code >= cal_code[mid]) lo = mid;
      else hi = mid;
    end
    dx = longint'(cal_code[hi]) - longint'(cal_code[lo]);
    if (dx == 0) return cal_mv[lo];
    num = (longint'(code) - longint'(cal_code[lo])) *
          (longint'(cal_mv[hi]) - longint'(cal_mv[lo]));
    v = longint'(cal_mv[lo]) + num / dx;   // sv division truncates toward zero
    if (v > MVMAX) v = MVMAX;
    if (v < MVMIN) v = MVMIN;
    return v[21:0];
  endfunction

  function automatic bit store_point(input logic [11:0] code,
                                     input logic signed [21:0] mv);
    if (cal_count >= NPTS) return 1'b0;
    cal_code[cal_count] = code;
    cal_mv[cal_count] = mv;
    cal_count++;
    return 1'b1;
  endfunction

  function automatic logic [31:0] apply_command(input covm_mode_e mode,
                                                input logic [11:0] code,
                                                input logic signed [21:0] kmv);
    bit ok;
    int j;
    logic [11:0] kc;
    logic signed [21:0] km;
    ok = 1'b1;
    case (mode)
      MODE_SAMPLE: begin
        volt_q = convert_code(code);
        if (!fault_q && longint'(volt_q) > longint'(limit_q)) begin
          relay_q = 1'b0;
          fault_q = 1'b1;
        end
      end
      MODE_CONNECT: if (!fault_q) relay_q = 1'b1;
      MODE_DISCON: relay_q = 1'b0;
      MODE_FRESET: begin
        relay_q = 1'b0;
        fault_q = 1'b0;
      end
      MODE_CLEAR: begin
        foreach (cal_code[i]) begin
          cal_code[i] = '0;
          cal_mv[i] = '0;
        end
        cal_count = 0;
        dz_code = '0;
      end
      MODE_DEADZ: begin
        dz_code = code;
        void'(store_point(code, kmv));
      end
      MODE_ADD: ok = store_point(code, kmv);
      default: begin
        if (cal_count < 2) ok = 1'b0;
        else begin
          // stable insertion sort by code
          for (int i = 1; i < cal_count; i++) begin
            kc = cal_code[i];
            km = cal_mv[i];
            j = i;
            while (j > 0 && cal_code[j-1] > kc) begin
              cal_code[j] = cal_code[j-1];
              cal_mv[j] = cal_mv[j-1];
              j--;
            end
            cal_code[j] = kc;
            cal_mv[j] = km;
          end
        end
      end
    endcase
    return {3'b000, 4'(cal_count), ok, relay_q, fault_q, volt_q};
  endfunction

  // send one command item, predicting its result at acceptance
  task automatic send_item(input covm_mode_e mode, input logic [11:0] code,
                           input logic signed [21:0] kmv);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'b0, kmv, code};
    do @(posedge clk_i); while (!s_axis_tready);
    result_q.push_back(apply_command(mode, code, kmv));
    s_axis_tvalid <= 1'b0;
    // the block is not ready again while it works on the item it took
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [20:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0;
    pwdata <= {11'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_q = value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_random(input int idx);
    logic [11:0] code;
    code = $urandom_range(4095);
    send_item(covm_mode_e'(idx), code, 22'($urandom));
  endtask

  // receiver: random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (hold_sink) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // result checker
  logic [31:0] want;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) report_mismatch("unexpected item", m_axis_tdata, '0);
      else begin
        want = result_q.pop_front();
        if (m_axis_tdata[21:0] !== want[21:0])
          report_mismatch("voltage_mv", m_axis_tdata[21:0], want[21:0]);
        if (m_axis_tdata[22] !== want[22])
          report_mismatch("over_voltage", m_axis_tdata[22], want[22]);
        if (m_axis_tdata[23] !== want[23])
          report_mismatch("relay_closed", m_axis_tdata[23], want[23]);
        if (m_axis_tdata[24] !== want[24])
          report_mismatch("accepted", m_axis_tdata[24], want[24]);
        if (m_axis_tdata[28:25] !== want[28:25])
          report_mismatch("point_count", m_axis_tdata[28:25], want[28:25]);
      end
    end
  end

  // watchdog on cycles without any accepted item
  int stuck = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck <= 0;
    else if (rst_ni) begin
      stuck <= stuck + 1;
      if (stuck >= WDOG_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // relay and fault commands on an empty table, including sample, finish and clear
  task automatic test_commands();
    send_item(MODE_SAMPLE, 12'hfff, 22'sd0);
    send_item(MODE_FINISH, 12'd0, 22'sd0);
    send_item(MODE_CONNECT, 12'd0, 22'sd0);
    send_item(MODE_DISCON, 12'd0, 22'sd0);
    send_item(MODE_CONNECT, 12'd0, 22'sd0);
    send_item(MODE_FRESET, 12'd0, 22'sd0);
    send_item(MODE_CLEAR, 12'd0, 22'sd0);
  endtask

  // unsorted table, finish sort, extremes, trip and latched fault
  task automatic test_table();
    send_item(MODE_DEADZ, 12'd10, -22'sd2097152);
    send_item(MODE_ADD, 12'hfff, 22'sd2097151);
    send_item(MODE_ADD, 12'd100, 22'sd1000);
    send_item(MODE_SAMPLE, 12'd50, 22'sd0);      // unsorted
    send_item(MODE_ADD, 12'd100, 22'sd9000);     // equal codes segment
    send_item(MODE_FINISH, 12'd0, 22'sd0);
    send_item(MODE_SAMPLE, 12'd5, 22'sd0);       // dead zone
    send_item(MODE_SAMPLE, 12'd10, 22'sd0);      // at dead zone
    send_item(MODE_SAMPLE, 12'd55, 22'sd0);      // negative voltage
    send_item(MODE_CONNECT, 12'd0, 22'sd0);
    send_item(MODE_SAMPLE, 12'd3000, 22'sd0);    // trips
    send_item(MODE_CONNECT, 12'd0, 22'sd0);      // stays open
    send_item(MODE_SAMPLE, 12'hffe, 22'sd0);
    send_item(MODE_FRESET, 12'd0, 22'sd0);
    for (int i = 0; i < 6; i++) send_item(MODE_ADD, 12'(i * 700), 22'sd0);
    send_item(MODE_ADD, 12'd1, 22'sd1);          // full table refused
    send_item(MODE_DEADZ, 12'd2, 22'sd1);
    send_item(MODE_SAMPLE, 12'hfff, 22'sd0);
  endtask

  // random traffic: mostly well-formed calibrations followed by samples
  task automatic test_random(input int loops);
    int n;
    for (int k = 0; k < loops; k++) begin
      if ($urandom_range(9) < 7) begin
        send_item(MODE_CLEAR, 12'($urandom), 22'($urandom));
        if ($urandom_range(1)) send_item(MODE_DEADZ, 12'($urandom_range(300)),
                                         22'($urandom_range(2000)));
        n = $urandom_range(2, 9);
        for (int i = 0; i < n; i++)
          send_item(MODE_ADD, 12'($urandom), 22'($urandom));
        if ($urandom_range(4) != 0) send_item(MODE_FINISH, '0, '0);
        send_item(MODE_CONNECT, '0, '0);
        repeat ($urandom_range(3, 8)) send_random($urandom_range(3) == 0 ?
                                                  $urandom_range(7) : 0);
        if ($urandom_range(1)) send_item(MODE_FRESET, '0, '0);
      end else begin
        repeat (8) send_random($urandom_range(7));
      end
    end
  endtask

  // receiver blocked while the sender keeps offering
  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      repeat (6) send_random(0);
      begin
        repeat (400) @(posedge clk_i);
        hold_sink = 1'b0;
      end
    join
    wait_drained();
  endtask

  initial begin
    foreach (cal_code[i]) begin
      cal_code[i] = '0;
      cal_mv[i] = '0;
    end
    cal_count = 0;
    dz_code = '0;
    fault_q = 1'b0;
    relay_q = 1'b0;
    volt_q = '0;
    limit_q = LimitRst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_commands();
    test_table();
    wait_drained();
    write_limit(21'd0);
    test_random(10);
    wait_drained();
    write_limit(21'h1fffff);
    idle_pct = 0;                 // stretch with no idling
    test_random(10);
    idle_pct = 29;
    wait_drained();
    test_backpressure();
    write_limit(21'd1000);
    test_random(15);
    wait_drained();
    write_limit(21'd2000000);
    test_random(10);
    wait_drained();

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
